### rtl/sha256_pkg.sv
package sha256_pkg;

  // Eight 32-bit words, as used for the chaining value and the round variables.
  typedef logic [7:0][31:0] word8_t;

  // Control from the sequencer to the round datapath.
  typedef struct packed {
    logic load;  // copy the chaining value into a..h
    logic step;  // perform one compression round
  } rnd_ctrl_t;

  // Control from the sequencer to the message schedule line.
  typedef struct packed {
    logic        push;  // shift one message word in at the tail
    logic        step;  // shift one expanded schedule word in
    logic [31:0] word;  // message word for a push
  } sched_ctrl_t;

  localparam int unsigned NUM_ROUNDS = 64;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Right rotation by a constant amount.
  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    logic [63:0] dbl;
    dbl = {x, x} >> n;
    return dbl[31:0];
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

### rtl/sha256_sched.sv
module sha256_sched (
  input  logic                   clk,
  input  sha256_pkg::sched_ctrl_t ctrl,
  output logic [31:0]            w_head
);
  import sha256_pkg::*;

  // Sixteen-word window: entry 0 is the word used by the current round.
  logic [15:0][31:0] line;
  logic [31:0]       expanded;
  logic [31:0]       tail_word;

  // Next schedule word from the fixed taps of the window.
  always_comb begin
    expanded  = line[0] + small_sigma0(line[1]) + line[9] + small_sigma1(line[14]);
    tail_word = ctrl.push ? ctrl.word : expanded;
  end

  // Shift the window by one word on a push or a round.
  always_ff @(posedge clk) begin
    if (ctrl.push || ctrl.step) begin
      for (int i = 0; i < 15; i++) begin
        line[i] <= line[i + 1];
      end
      line[15] <= tail_word;
    end
  end

  assign w_head = line[0];

endmodule

### rtl/sha256_round.sv
module sha256_round (
  input  logic                  clk,
  input  sha256_pkg::rnd_ctrl_t ctrl,
  input  sha256_pkg::word8_t    chain,
  input  logic [31:0]           k_word,
  input  logic [31:0]           w_word,
  output sha256_pkg::word8_t    vars
);
  import sha256_pkg::*;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] choose;
  logic [31:0] major;

  // One compression round on a..h, held as vars[0]..vars[7].
  always_comb begin
    choose = (vars[4] & vars[5]) ^ (~vars[4] & vars[6]);
    major  = (vars[0] & vars[1]) ^ (vars[0] & vars[2]) ^ (vars[1] & vars[2]);
    t1     = vars[7] + big_sigma1(vars[4]) + choose + k_word + w_word;
    t2     = big_sigma0(vars[0]) + major;
  end

  // Working variables: loaded from the chaining value, then stepped per round.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      vars <= chain;
    end else if (ctrl.step) begin
      vars[7] <= vars[6];
      vars[6] <= vars[5];
      vars[5] <= vars[4];
      vars[4] <= vars[3] + t1;
      vars[3] <= vars[2];
      vars[2] <= vars[1];
      vars[1] <= vars[0];
      vars[0] <= t1 + t2;
    end
  end

endmodule

### rtl/sha256_hash_engine_core.sv
// Channel   Direction  Handshake                    Payload
// data      in         data_valid / data_ready      data_word, byte_count, last_item
// digest    out        digest_valid / digest_ready  digest_word, word_index, last_word
//
// A word that does not complete a 64-byte block is simply taken; one that does also starts
// a compression: 64 rounds of the single round unit, then one fold.
// After a final word come the 0x80 byte, the zero and length words, a step ending zero fill
// and a compression per block closed; then eight digest words, one a cycle unless stalled.
// Reset is synchronous and active high; it restores the initial hash and clears counts.
// data_ready is low in reset, while compressing or padding and until the digest is taken.
module sha256_hash_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_ready,
  input  logic [31:0] data_word,
  input  logic [2:0]  byte_count,
  input  logic        last_item,
  output logic        digest_valid,
  input  logic        digest_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha256_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_PAD80 = 4'd1;
  localparam logic [3:0] S_ZERO  = 4'd2;
  localparam logic [3:0] S_LENHI = 4'd3;
  localparam logic [3:0] S_LENLO = 4'd4;
  localparam logic [3:0] S_COMP  = 4'd5;
  localparam logic [3:0] S_ADD   = 4'd6;
  localparam logic [3:0] S_OUT   = 4'd7;

  logic [3:0]  state;
  logic [3:0]  state_next;
  logic [3:0]  ret;
  logic [3:0]  ret_next;
  logic [5:0]  rnd;
  logic [3:0]  wcnt;
  logic [1:0]  lane;
  logic [1:0]  lane_next;
  logic [31:0] acc;
  logic [31:0] acc_next;
  logic [63:0] bit_length;
  logic [2:0]  word_sel;
  word8_t      chain;
  word8_t      vars;

  logic        in_fire;
  logic        out_fire;
  logic [2:0]  cnt_sat;
  logic [2:0]  merge_cnt;
  logic [31:0] merge_data;
  logic [31:0] keep_mask;
  logic [63:0] merged;
  logic [2:0]  total;
  logic [31:0] w_head;

  rnd_ctrl_t   rctl;
  sched_ctrl_t sctl;

  assign in_fire  = data_valid && data_ready;
  assign out_fire = digest_valid && digest_ready;

  // Byte merge: new bytes are placed after the partial word already held.
  always_comb begin
    cnt_sat    = (byte_count > 3'd4) ? 3'd4 : byte_count;
    merge_cnt  = (state == S_PAD80) ? 3'd1 : cnt_sat;
    merge_data = (state == S_PAD80) ? 32'h8000_0000 : data_word;
    keep_mask  = ~(32'hFFFF_FFFF >> {merge_cnt, 3'b000});
    merged     = {acc, 32'h0} | ({merge_data & keep_mask, 32'h0} >> {lane, 3'b000});
    total      = {1'b0, lane} + merge_cnt;
  end

  // Sequencer.
  always_comb begin
    state_next  = state;
    ret_next    = ret;
    lane_next   = lane;
    acc_next    = acc;
    rctl        = '0;
    sctl        = '0;
    sctl.word   = acc;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          lane_next = total[1:0];
          if (total[2]) begin
            sctl.push = 1'b1;
            sctl.word = merged[63:32];
            acc_next  = merged[31:0];
          end else begin
            acc_next  = merged[63:32];
          end
          state_next = last_item ? S_PAD80 : S_IDLE;
          if (total[2] && wcnt == 4'd15) begin
            ret_next   = state_next;
            state_next = S_COMP;
            rctl.load  = 1'b1;
          end
        end
      end
      S_PAD80: begin
        lane_next  = total[1:0];
        state_next = S_ZERO;
        if (total[2]) begin
          sctl.push = 1'b1;
          sctl.word = merged[63:32];
          acc_next  = merged[31:0];
          if (wcnt == 4'd15) begin
            ret_next   = S_ZERO;
            state_next = S_COMP;
            rctl.load  = 1'b1;
          end
        end else begin
          acc_next = merged[63:32];
        end
      end
      S_ZERO: begin
        if (wcnt == 4'd14 && lane == 2'd0) begin
          state_next = S_LENHI;
        end else begin
          // Flush the partial word or push a zero word.
          sctl.push = 1'b1;
          sctl.word = acc;
          acc_next  = 32'h0;
          lane_next = 2'd0;
          if (wcnt == 4'd15) begin
            ret_next   = S_ZERO;
            state_next = S_COMP;
            rctl.load  = 1'b1;
          end
        end
      end
      S_LENHI: begin
        sctl.push  = 1'b1;
        sctl.word  = bit_length[63:32];
        state_next = S_LENLO;
      end
      S_LENLO: begin
        sctl.push  = 1'b1;
        sctl.word  = bit_length[31:0];
        ret_next   = S_OUT;
        state_next = S_COMP;
        rctl.load  = 1'b1;
      end
      S_COMP: begin
        rctl.step = 1'b1;
        sctl.step = 1'b1;
        if (rnd == 6'(NUM_ROUNDS - 1)) begin
          state_next = S_ADD;
        end
      end
      S_ADD: begin
        state_next = ret;
      end
      S_OUT: begin
        if (out_fire && word_sel == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control and length registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ret        <= S_IDLE;
      rnd        <= '0;
      wcnt       <= '0;
      lane       <= '0;
      acc        <= '0;
      bit_length <= '0;
      word_sel   <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      lane  <= lane_next;
      acc   <= acc_next;
      if (sctl.push) begin
        wcnt <= wcnt + 4'd1;
      end
      if (state == S_COMP) begin
        rnd <= rnd + 6'd1;
      end else begin
        rnd <= '0;
      end
      if (in_fire) begin
        bit_length <= bit_length + {58'h0, cnt_sat, 3'b000};
      end
      if (out_fire) begin
        word_sel <= word_sel + 3'd1;
        if (word_sel == 3'd7) begin
          bit_length <= '0;
        end
      end
    end
  end

  // Chaining value: folded after each block, restored once the digest is taken.
  always_ff @(posedge clk) begin
    if (rst || (out_fire && word_sel == 3'd7)) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= H_INIT[i];
      end
    end else if (state == S_ADD) begin
      for (int i = 0; i < 8; i++) begin
        chain[i] <= chain[i] + vars[i];
      end
    end
  end

  sha256_sched u_sched (
    .clk    (clk),
    .ctrl   (sctl),
    .w_head (w_head)
  );

  sha256_round u_round (
    .clk    (clk),
    .ctrl   (rctl),
    .chain  (chain),
    .k_word (ROUND_K[rnd]),
    .w_word (w_head),
    .vars   (vars)
  );

  // Handshake and digest payload.
  assign data_ready   = (state == S_IDLE) && !rst;
  assign digest_valid = (state == S_OUT);
  assign digest_word  = chain[word_sel];
  assign word_index   = word_sel;
  assign last_word    = (word_sel == 3'd7);

endmodule

### rtl/sha256_checker.sv
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        data_ready,
  input logic        digest_valid,
  input logic        digest_ready,
  input logic [31:0] digest_word,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // The engine never takes a word while a digest is on offer.
  assert property (@(posedge clk) disable iff (rst) !(data_ready && digest_valid))
    else $error("data_ready high while a digest word is pending");

  // The final flag marks the eighth digest word exactly.
  assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (last_word == (word_index == 3'd7)))
    else $error("last_word does not match word_index");

  // Digest words come in order without gaps.
  assert property (@(posedge clk) disable iff (rst)
    (digest_valid && digest_ready && !last_word) |=>
      (digest_valid && word_index == $past(word_index) + 3'd1))
    else $error("digest word sequence broken");

  // A stalled digest word holds steady.
  assert property (@(posedge clk) disable iff (rst)
    (digest_valid && !digest_ready) |=>
      (digest_valid && $stable(digest_word) && $stable(word_index)))
    else $error("stalled digest word changed");

endmodule

bind sha256_hash_engine_core sha256_checker u_checker (.*);
